### rtl/rcps_pkg.sv
`timescale 1ns / 1ps
package rcps_pkg;

   localparam int CoordW  = 16;
   localparam int SizeW   = 15;
   localparam int KindW   = 4;
   localparam int CsrW    = 64;
   localparam int OutSlotW = 4;
   localparam int MaxEvents = 30;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_ERASE = 3'd1,
      OP_MARK  = 3'd2,
      OP_PURGE = 3'd3,
      OP_SWEEP = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_ROWS_A = 2'd0,
      CSR_ROWS_B = 2'd1,
      CSR_ROWS_C = 2'd2,
      CSR_ROWS_D = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic [SizeW-1:0]         w;
      logic [SizeW-1:0]         h;
   } rect_type;

   typedef struct packed {
      logic add;
      logic erase;
      logic mark;
      logic purge;
   } cell_ctl_type;

   function automatic logic reacts(logic [4*CsrW-1:0] tbl, logic [KindW-1:0] t,
                                   logic [KindW-1:0] o, logic [KindW:0] nk);
      return ({1'b0, t} < nk) && ({1'b0, o} < nk) && tbl[{t, o}];
   endfunction

endpackage

### rtl/rect_collider_pair_sweep.sv
`timescale 1ns / 1ps
// Rectangle table with pairwise overlap sweep. Add, erase, mark and purge
// acknowledge the cycle after start and busy stays low, as does a sweep of an
// empty row or one with events blocked. Any other row sweep walks the later
// slots one per cycle through the row of slot cells, but a pair that raises two
// events keeps its slot while the second event goes out; busy is high until the
// closing acknowledge. Results are strobed for one cycle and cannot be stalled.
module rect_collider_pair_sweep #(
   parameter int NUM_SLOTS = 16,
   parameter int NUM_KINDS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_type,
   input  logic [3:0]                    req_slot,
   input  logic signed [15:0]            req_rect_x,
   input  logic signed [15:0]            req_rect_y,
   input  logic [14:0]                   req_rect_w,
   input  logic [14:0]                   req_rect_h,
   input  logic [3:0]                    req_collider_kind,
   input  logic                          req_has_handler,
   input  logic                          req_events_blocked,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [rcps_pkg::CsrW-1:0]     csr_wdata,
   output logic                          rsp_strobe,
   output logic                          rsp_result_kind,
   output logic [3:0]                    rsp_first_slot,
   output logic [3:0]                    rsp_second_slot,
   output logic                          rsp_success,
   output logic                          rsp_last
);
   import rcps_pkg::*;

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type              state_ff;
   logic [CsrW-1:0]        rows_ff [4];
   logic [4*CsrW-1:0]      tbl;
   rect_type               probe_ff;
   logic [KindW-1:0]       pkind_ff;
   logic                   phand_ff;
   logic [SW-1:0]          row_ff;
   logic [SW:0]            idx_ff;
   logic                   phase_ff;
   logic [4:0]             n_ff;
   logic                   strobe_ff, kind_ff, ok_ff, last_ff;
   logic [3:0]             first_ff, second_ff;

   logic                   accept, slot_ok, row_valid, erase_ok;
   logic [SW-1:0]          req_idx, cur, add_idx;
   logic                   full;
   logic [NUM_SLOTS:0]     free_chain;
   logic [NUM_SLOTS-1:0]   taken_v, valid_v, hit_v, hand_v;
   rect_type               rect_v [NUM_SLOTS];
   logic [KindW-1:0]       kind_v [NUM_SLOTS];
   rect_type               new_rect;
   logic                   e1, e2, e2_room;
   logic                   is_add, is_erase, is_mark, is_purge, is_sweep;

   assign busy    = (state_ff == ST_SCAN);
   assign accept  = start && !busy;
   assign tbl     = {rows_ff[CSR_ROWS_D], rows_ff[CSR_ROWS_C],
                     rows_ff[CSR_ROWS_B], rows_ff[CSR_ROWS_A]};
   assign req_idx = SW'(req_slot);
   assign slot_ok = ({3'b000, req_slot} < 7'(NUM_SLOTS));
   assign row_valid = slot_ok && valid_v[req_idx];
   assign erase_ok  = row_valid;

   assign is_add   = accept && (req_type == OP_ADD);
   assign is_erase = accept && (req_type == OP_ERASE);
   assign is_mark  = accept && (req_type == OP_MARK);
   assign is_purge = accept && (req_type == OP_PURGE);
   assign is_sweep = accept && (req_type == OP_SWEEP);

   assign new_rect = '{x: req_rect_x, y: req_rect_y, w: req_rect_w, h: req_rect_h};
   assign free_chain[0] = 1'b0;
   assign full = !free_chain[NUM_SLOTS];

   genvar g;
   generate
      for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
         cell_ctl_type ctl;
         assign ctl.add   = is_add;
         assign ctl.erase = is_erase && slot_ok && (req_idx == SW'(g));
         assign ctl.mark  = is_mark && (g != 0);
         assign ctl.purge = is_purge;
         rcps_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .new_rect    (new_rect),
            .new_kind    (req_collider_kind),
            .new_handler (req_has_handler),
            .probe       (probe_ff),
            .free_in     (free_chain[g]),
            .free_out    (free_chain[g+1]),
            .taken       (taken_v[g]),
            .valid       (valid_v[g]),
            .rect        (rect_v[g]),
            .kind        (kind_v[g]),
            .handler     (hand_v[g]),
            .hit         (hit_v[g])
         );
      end
   endgenerate

   always_comb begin
      add_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (taken_v[i]) begin
            add_idx = add_idx | SW'(i);
         end
      end
   end

   assign cur     = idx_ff[SW-1:0];
   assign e1      = !phase_ff && hit_v[cur] && phand_ff && (n_ff < 5'(MaxEvents))
                    && reacts(tbl, pkind_ff, kind_v[cur], 5'(NUM_KINDS));
   assign e2_room = (n_ff + 5'(e1)) < 5'(MaxEvents);
   assign e2      = hit_v[cur] && hand_v[cur] && e2_room
                    && reacts(tbl, kind_v[cur], pkind_ff, 5'(NUM_KINDS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (csr_we) begin
         rows_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (is_sweep) begin
         probe_ff <= rect_v[req_idx];
         pkind_ff <= kind_v[req_idx];
         phand_ff <= hand_v[req_idx];
         row_ff   <= req_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         idx_ff    <= '0;
         phase_ff  <= 1'b0;
         n_ff      <= '0;
         kind_ff   <= 1'b0;
         first_ff  <= '0;
         second_ff <= '0;
         ok_ff     <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  strobe_ff <= 1'b1;
                  kind_ff   <= 1'b0;
                  first_ff  <= '0;
                  second_ff <= '0;
                  ok_ff     <= 1'b0;
                  last_ff   <= 1'b1;
                  if (is_add) begin
                     first_ff <= full ? 4'd0 : 4'(add_idx);
                     ok_ff    <= !full;
                  end else if (is_erase) begin
                     ok_ff <= erase_ok;
                  end else if (is_sweep && row_valid && !req_events_blocked) begin
                     strobe_ff <= 1'b0;
                     state_ff  <= ST_SCAN;
                     idx_ff    <= (SW+1)'(req_idx) + 1'b1;
                     phase_ff  <= 1'b0;
                     n_ff      <= '0;
                  end
               end
            end
            ST_SCAN: begin
               if (idx_ff == (SW+1)'(NUM_SLOTS)) begin
                  strobe_ff <= 1'b1;
                  kind_ff   <= 1'b0;
                  first_ff  <= '0;
                  second_ff <= '0;
                  ok_ff     <= 1'b0;
                  last_ff   <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else if (e1) begin
                  strobe_ff <= 1'b1;
                  kind_ff   <= 1'b1;
                  first_ff  <= 4'(row_ff);
                  second_ff <= 4'(cur);
                  ok_ff     <= 1'b0;
                  last_ff   <= 1'b0;
                  n_ff      <= n_ff + 1'b1;
                  if (e2) begin
                     phase_ff <= 1'b1;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  if (e2) begin
                     strobe_ff <= 1'b1;
                     kind_ff   <= 1'b1;
                     first_ff  <= 4'(cur);
                     second_ff <= 4'(row_ff);
                     ok_ff     <= 1'b0;
                     last_ff   <= 1'b0;
                     n_ff      <= n_ff + 1'b1;
                  end
                  phase_ff <= 1'b0;
                  idx_ff   <= idx_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_first_slot  = first_ff;
   assign rsp_second_slot = second_ff;
   assign rsp_success     = ok_ff;
   assign rsp_last        = last_ff;

endmodule

### rtl/rcps_cell.sv
`timescale 1ns / 1ps
module rcps_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  rcps_pkg::cell_ctl_type     ctl,
   input  rcps_pkg::rect_type         new_rect,
   input  logic [rcps_pkg::KindW-1:0] new_kind,
   input  logic                       new_handler,
   input  rcps_pkg::rect_type         probe,
   input  logic                       free_in,
   output logic                       free_out,
   output logic                       taken,
   output logic                       valid,
   output rcps_pkg::rect_type         rect,
   output logic [rcps_pkg::KindW-1:0] kind,
   output logic                       handler,
   output logic                       hit
);
   import rcps_pkg::*;

   logic                valid_ff, valid_in;
   logic                mark_ff, mark_in;
   rect_type            rect_ff;
   logic [KindW-1:0]    kind_ff;
   logic                handler_ff;
   logic signed [17:0]  ax, ay, aw, ah, bx, by, bw, bh;

   assign taken    = ctl.add && !valid_ff && !free_in;
   assign free_out = free_in || !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      mark_in  = mark_ff;
      if (taken) begin
         valid_in = 1'b1;
         mark_in  = 1'b0;
      end
      if (ctl.erase) begin
         valid_in = 1'b0;
         mark_in  = 1'b0;
      end
      if (ctl.mark && valid_ff) begin
         mark_in = 1'b1;
      end
      if (ctl.purge && valid_ff && mark_ff) begin
         valid_in = 1'b0;
         mark_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mark_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (taken) begin
         rect_ff    <= new_rect;
         kind_ff    <= new_kind;
         handler_ff <= new_handler;
      end
   end

   assign ax = 18'(probe.x);
   assign ay = 18'(probe.y);
   assign aw = {3'b000, probe.w};
   assign ah = {3'b000, probe.h};
   assign bx = 18'(rect_ff.x);
   assign by = 18'(rect_ff.y);
   assign bw = {3'b000, rect_ff.w};
   assign bh = {3'b000, rect_ff.h};

   assign hit = valid_ff && (ax < bx + bw) && (ax + aw > bx)
                && (ay < by + bh) && (ay + ah > by);

   assign valid   = valid_ff;
   assign rect    = rect_ff;
   assign kind    = kind_ff;
   assign handler = handler_ff;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import rcps_pkg::*;

   localparam int NSLOT = 16;

   typedef struct {
      logic       kind;
      logic [3:0] first;
      logic [3:0] second;
      logic       ok;
      logic       last;
   } rsp_word_type;

   class collide_sb;
      logic [63:0]       rows [4];
      bit                vld [NSLOT];
      bit                mark [NSLOT];
      int                px [NSLOT], py [NSLOT], sw [NSLOT], sh [NSLOT];
      logic [3:0]        knd [NSLOT];
      bit                hnd [NSLOT];
      rsp_word_type      pending [$];
      int                errors;
      int                seen;
      int                events;

      function new();
         foreach (rows[i]) rows[i] = '0;
         foreach (vld[i]) begin
            vld[i] = 0;
            mark[i] = 0;
         end
         errors = 0;
         seen = 0;
         events = 0;
      endfunction

      function void push(logic k, int a, int b, logic ok, logic l);
         rsp_word_type w;
         w.kind = k;
         w.first = a[3:0];
         w.second = b[3:0];
         w.ok = ok;
         w.last = l;
         pending.push_back(w);
      endfunction

      function bit kind_reacts(logic [3:0] t, logic [3:0] o);
         return rows[t[3:2]][{t[1:0], o}];
      endfunction

      function bit touching(int a, int b);
         return px[a] < px[b] + sw[b] && px[a] + sw[a] > px[b] &&
                py[a] < py[b] + sh[b] && py[a] + sh[a] > py[b];
      endfunction

      function void note_request(logic [2:0] op, logic [3:0] s, logic signed [15:0] x,
                                 logic signed [15:0] y, logic [14:0] w, logic [14:0] h,
                                 logic [3:0] k, logic hd, logic blk);
         int n;
         int i;
         n = 0;
         case (op)
            OP_ADD: begin
               for (i = 0; i < NSLOT; i++) if (!vld[i]) break;
               if (i < NSLOT) begin
                  vld[i] = 1;
                  mark[i] = 0;
                  px[i] = x;
                  py[i] = y;
                  sw[i] = w;
                  sh[i] = h;
                  knd[i] = k;
                  hnd[i] = hd;
                  push(0, i, 0, 1, 1);
               end else push(0, 0, 0, 0, 1);
            end
            OP_ERASE: begin
               if (vld[s]) begin
                  vld[s] = 0;
                  mark[s] = 0;
                  push(0, 0, 0, 1, 1);
               end else push(0, 0, 0, 0, 1);
            end
            OP_MARK: begin
               for (i = 1; i < NSLOT; i++) if (vld[i]) mark[i] = 1;
               push(0, 0, 0, 0, 1);
            end
            OP_PURGE: begin
               for (i = 0; i < NSLOT; i++)
                  if (vld[i] && mark[i]) begin
                     vld[i] = 0;
                     mark[i] = 0;
                  end
               push(0, 0, 0, 0, 1);
            end
            OP_SWEEP: begin
               if (vld[s] && !blk)
                  for (i = s + 1; i < NSLOT; i++) begin
                     if (!vld[i] || !touching(s, i)) continue;
                     if (n < MaxEvents && hnd[s] && kind_reacts(knd[s], knd[i])) begin
                        push(1, s, i, 0, 0);
                        n++;
                     end
                     if (n < MaxEvents && hnd[i] && kind_reacts(knd[i], knd[s])) begin
                        push(1, i, s, 0, 0);
                        n++;
                     end
                  end
               events += n;
               push(0, 0, 0, 0, 1);
            end
            default: push(0, 0, 0, 0, 1);
         endcase
      endfunction

      function void check_word(rsp_word_type a);
         rsp_word_type e;
         seen++;
         if (pending.size() == 0) begin
            $error("unexpected word kind=%0d first=%0d", a.kind, a.first);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.kind !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, a.kind);
            errors++;
         end
         if (a.first !== e.first) begin
            $error("first_slot exp %0d got %0d", e.first, a.first);
            errors++;
         end
         if (a.second !== e.second) begin
            $error("second_slot exp %0d got %0d", e.second, a.second);
            errors++;
         end
         if (a.ok !== e.ok) begin
            $error("success exp %0d got %0d", e.ok, a.ok);
            errors++;
         end
         if (a.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, a.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_type = '0;
   logic [3:0] req_slot = '0;
   logic signed [15:0] req_rect_x = '0, req_rect_y = '0;
   logic [14:0] req_rect_w = '0, req_rect_h = '0;
   logic [3:0] req_collider_kind = '0;
   logic req_has_handler = 0, req_events_blocked = 0;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [CsrW-1:0] csr_wdata = '0;
   logic rsp_strobe, rsp_result_kind, rsp_success, rsp_last;
   logic [3:0] rsp_first_slot, rsp_second_slot;

   collide_sb sb = new();
   int gap_pct = 0;
   int n_req = 0;

   rect_collider_pair_sweep dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_strobe) begin
         w.kind = rsp_result_kind;
         w.first = rsp_first_slot;
         w.second = rsp_second_slot;
         w.ok = rsp_success;
         w.last = rsp_last;
         sb.check_word(w);
      end
      if (!reset && start && !busy) begin
         sb.note_request(req_type, req_slot, req_rect_x, req_rect_y, req_rect_w,
                         req_rect_h, req_collider_kind, req_has_handler,
                         req_events_blocked);
         n_req++;
      end
   end

   task automatic send(logic [2:0] op, logic [3:0] s, logic signed [15:0] x,
                       logic signed [15:0] y, logic [14:0] w, logic [14:0] h,
                       logic [3:0] k, logic hd, logic blk);
      if ($urandom_range(99) < gap_pct) begin
         start <= 0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
      req_type <= op;
      req_slot <= s;
      req_rect_x <= x;
      req_rect_y <= y;
      req_rect_w <= w;
      req_rect_h <= h;
      req_collider_kind <= k;
      req_has_handler <= hd;
      req_events_blocked <= blk;
      start <= 1;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_op(logic [2:0] op, logic [3:0] s, logic blk);
      send(op, s, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
           4'($urandom), 1'($urandom), blk);
   endtask

   task automatic add_near(logic hd);
      send(OP_ADD, 4'($urandom), 16'($urandom_range(0, 200) - 100),
           16'($urandom_range(0, 200) - 100), 15'($urandom_range(0, 120)),
           15'($urandom_range(0, 120)), 4'($urandom), hd, 0);
   endtask

   task automatic quiesce();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_rows(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [63:0] d);
      logic [63:0] v [4];
      v[0] = a;
      v[1] = b;
      v[2] = c;
      v[3] = d;
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         sb.rows[i] = v[i];
      end
      csr_we <= 0;
   endtask

   task automatic random_phase(int cnt);
      int r;
      for (int i = 0; i < cnt; i++) begin
         r = $urandom_range(99);
         if (r < 40) add_near($urandom_range(99) < 80);
         else if (r < 70) send_op(OP_SWEEP, 4'($urandom), $urandom_range(9) == 0);
         else if (r < 82) send_op(OP_ERASE, 4'($urandom), 1'($urandom));
         else if (r < 88) send_op(OP_MARK, 4'($urandom), 1'($urandom));
         else if (r < 94) send_op(OP_PURGE, 4'($urandom), 1'($urandom));
         else send_op(3'($urandom_range(5, 7)), 4'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_rows('1, '1, '1, '1);
      send(OP_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0);
      send(OP_ERASE, 3, 0, 0, 0, 0, 0, 0, 0);
      send(OP_ADD, 0, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 0, 1, 0);
      send(OP_ADD, 0, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 15, 1, 1);
      send(OP_ADD, 0, 0, 0, 0, 0, 7, 1, 0);
      send(OP_ADD, 0, -10, -10, 20, 20, 3, 1, 0);
      send(OP_ADD, 0, 10, 10, 5, 5, 3, 0, 0);
      for (int i = 0; i < 12; i++) add_near(1);
      send_op(OP_ADD, 0, 0);
      send(OP_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0);
      send(OP_SWEEP, 0, 0, 0, 0, 0, 0, 0, 1);
      send(OP_SWEEP, 15, 0, 0, 0, 0, 0, 0, 0);
      send(OP_ERASE, 15, 0, 0, 0, 0, 0, 0, 0);
      send(OP_MARK, 0, 0, 0, 0, 0, 0, 0, 0);
      send(OP_ERASE, 4, 0, 0, 0, 0, 0, 0, 0);
      send(OP_PURGE, 0, 0, 0, 0, 0, 0, 0, 0);
      send(5, 0, 0, 0, 0, 0, 0, 0, 0);
      send(7, 0, 0, 0, 0, 0, 0, 0, 0);
      quiesce();

      write_rows({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
      gap_pct = 17;
      random_phase(70);
      quiesce();
      write_rows('0, '0, '0, '0);
      gap_pct = 63;
      random_phase(30);
      quiesce();
      write_rows({$urandom, $urandom}, '1, {$urandom, $urandom}, {$urandom, $urandom});
      gap_pct = 0;
      random_phase(90);
      quiesce();

      $display("covered %0d requests, %0d result words, %0d collision events",
               n_req, sb.seen, sb.events);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
